[sv/differential_drive_odometry_unit_assert.svh]
// Assertion macros for the odometry unit.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define ODU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked during reset as well
`define ODU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ODU_ASSERT(lbl, prop, msg)
`define ODU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[sv/odo_pkg.sv]
package odo_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH = 8'd1;

    localparam logic [15:0] RADIUS_RESET = 16'd6554;
    localparam logic [19:0] ITW_RESET    = 20'd133747;

    // pi/30 in Q0.32, 2^8/(2*pi) in Q6.24, CORDIC gain in Q2.30
    localparam logic [28:0]        PI30_Q32        = 29'd449767923;
    localparam logic [29:0]        INV2PI_Q24      = 30'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] left_rpm;
        logic signed [15:0] right_rpm;
        logic [19:0]        elapsed_time;
    } t_odo_in;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [23:0]        heading;
        logic signed [31:0] forward_speed;
        logic signed [31:0] yaw_rate;
    } t_odo_out;

    // arctangent of 2^-i in heading units
    function automatic logic [23:0] atan_step(input logic [4:0] idx);
        logic [23:0] r;
        case (idx)
            5'd0:    r = 24'd2097152;
            5'd1:    r = 24'd1238021;
            5'd2:    r = 24'd654136;
            5'd3:    r = 24'd332050;
            5'd4:    r = 24'd166669;
            5'd5:    r = 24'd83416;
            5'd6:    r = 24'd41718;
            5'd7:    r = 24'd20860;
            5'd8:    r = 24'd10430;
            5'd9:    r = 24'd5215;
            5'd10:   r = 24'd2608;
            5'd11:   r = 24'd1304;
            5'd12:   r = 24'd652;
            5'd13:   r = 24'd326;
            5'd14:   r = 24'd163;
            5'd15:   r = 24'd81;
            5'd16:   r = 24'd41;
            5'd17:   r = 24'd20;
            5'd18:   r = 24'd10;
            5'd19:   r = 24'd5;
            5'd20:   r = 24'd3;
            5'd21:   r = 24'd1;
            5'd22:   r = 24'd1;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

[sv/differential_drive_odometry_unit.sv]
// Channel   Direction  Handshake            Payload
// in        input      i_in_valid/o_in_stall   odo_pkg::t_odo_in
// out       output     o_out_valid/i_out_stall odo_pkg::t_odo_out
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request at a time. A shared shift-add multiplier retires one multiplier bit per
// cycle and stops when the remaining bits are zero; a request passes the accept, four
// products, CORDIC_STEPS rotation steps, six more products and the final update, so
// ten products in all.
// Reset (synchronous, active low) clears the pose and loads the register defaults.
// A waiting result does not block the next request; only the final update waits on it.
`include "differential_drive_odometry_unit_assert.svh"

module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  odo_pkg::t_odo_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output odo_pkg::t_odo_out                   o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
    localparam int unsigned SH_V = 49 - FRAC_BITS;
    localparam int unsigned SH_D = 48 - FRAC_BITS;
    localparam int unsigned SH_F = FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_COR  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    localparam logic [3:0] PH_RC  = 4'd0;
    localparam logic [3:0] PH_V   = 4'd1;
    localparam logic [3:0] PH_D   = 4'd2;
    localparam logic [3:0] PH_W   = 4'd3;
    localparam logic [3:0] PH_VC  = 4'd4;
    localparam logic [3:0] PH_TX  = 4'd5;
    localparam logic [3:0] PH_VS  = 4'd6;
    localparam logic [3:0] PH_TY  = 4'd7;
    localparam logic [3:0] PH_P   = 4'd8;
    localparam logic [3:0] PH_ANG = 4'd9;

    localparam logic signed [24:0] QUARTER = 25'sd4194304;
    localparam logic signed [24:0] HALF    = 25'sd8388608;

    function automatic logic [63:0] rnd(input logic [63:0] m, input int unsigned s);
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
        end else begin
            r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    logic [1:0]         r_state;
    logic [3:0]         r_phase;
    logic [63:0]        r_a, r_b, r_p;
    logic signed [16:0] r_sum, r_diff;
    logic [19:0]        r_dt;
    logic [63:0]        r_rc;
    logic signed [31:0] r_v, r_w;
    logic signed [47:0] r_dx, r_dy;
    logic [23:0]        r_dang;
    logic signed [33:0] r_cx, r_cy, r_cs, r_sn;
    logic signed [24:0] r_ca;
    logic               r_flip;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [47:0] r_x, r_y;
    logic [23:0]        r_h;
    logic [15:0]        r_radius;
    logic [19:0]        r_itw;
    logic               r_out_valid;
    odo_pkg::t_odo_out  r_out;

    logic [16:0]        sum_mag, diff_mag;
    logic [31:0]        v_mag, w_mag;
    logic [33:0]        sn_mag, cs_fin_mag;
    logic signed [24:0] ang_sx, ang0;
    logic               flip0;
    logic signed [33:0] cor_dx, cor_dy, cx_nx, cy_nx, cs_fin, sn_fin;
    logic signed [24:0] atan_sx, ca_nx;
    logic signed [48:0] x_sum, y_sum;
    logic signed [47:0] x_new, y_new;
    logic [23:0]        h_new;
    logic [63:0]        ang_rnd;
    logic [23:0]        ang_bits;

    assign sum_mag  = r_sum[16]  ? 17'(-r_sum)  : 17'(r_sum);
    assign diff_mag = r_diff[16] ? 17'(-r_diff) : 17'(r_diff);
    assign v_mag    = r_v[31] ? 32'(-r_v) : 32'(r_v);
    assign w_mag    = r_w[31] ? 32'(-r_w) : 32'(r_w);
    assign sn_mag   = r_sn[33] ? 34'(-r_sn) : 34'(r_sn);

    // fold the heading into +-quarter turn
    always_comb begin
        ang_sx = $signed({r_h[23], r_h});
        ang0   = ang_sx;
        flip0  = 1'b0;
        if (ang_sx > QUARTER) begin
            ang0  = ang_sx - HALF;
            flip0 = 1'b1;
        end else if (ang_sx < -QUARTER) begin
            ang0  = ang_sx + HALF;
            flip0 = 1'b1;
        end
    end

    always_comb begin
        cor_dx  = r_cy >>> r_cnt;
        cor_dy  = r_cx >>> r_cnt;
        atan_sx = $signed({1'b0, odo_pkg::atan_step(5'(r_cnt))});
        if (!r_ca[24]) begin
            cx_nx = r_cx - cor_dx;
            cy_nx = r_cy + cor_dy;
            ca_nx = r_ca - atan_sx;
        end else begin
            cx_nx = r_cx + cor_dx;
            cy_nx = r_cy - cor_dy;
            ca_nx = r_ca + atan_sx;
        end
        cs_fin     = r_flip ? -cx_nx : cx_nx;
        sn_fin     = r_flip ? -cy_nx : cy_nx;
        cs_fin_mag = cs_fin[33] ? 34'(-cs_fin) : 34'(cs_fin);
    end

    always_comb begin
        ang_rnd  = r_p + (64'd1 << 23);
        ang_bits = ang_rnd[47:24];
    end

    always_comb begin
        x_sum = {r_x[47], r_x} + {r_dx[47], r_dx};
        y_sum = {r_y[47], r_y} + {r_dy[47], r_dy};
        x_new = (x_sum[48] != x_sum[47]) ? {x_sum[48], {47{~x_sum[48]}}} : x_sum[47:0];
        y_new = (y_sum[48] != y_sum[47]) ? {y_sum[48], {47{~y_sum[48]}}} : y_sum[47:0];
        h_new = r_h + r_dang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_RC;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_h         <= '0;
            r_radius    <= odo_pkg::RADIUS_RESET;
            r_itw       <= odo_pkg::ITW_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    odo_pkg::REG_WHEEL_RADIUS:    r_radius <= i_cfg_data[15:0];
                    odo_pkg::REG_INV_TRACK_WIDTH: r_itw    <= i_cfg_data[19:0];
                    default: ;
                endcase
            end

            // the update state refills the output itself
            if (r_out_valid && !i_out_stall && (r_state != ST_UPD)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sum   <= $signed({i_in.right_rpm[15], i_in.right_rpm})
                                 + $signed({i_in.left_rpm[15], i_in.left_rpm});
                        r_diff  <= $signed({i_in.right_rpm[15], i_in.right_rpm})
                                 - $signed({i_in.left_rpm[15], i_in.left_rpm});
                        r_dt    <= i_in.elapsed_time;
                        r_a     <= 64'(odo_pkg::PI30_Q32);
                        r_b     <= 64'(r_radius);
                        r_p     <= '0;
                        r_phase <= PH_RC;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_b != 64'd0) begin
                        if (r_b[0]) begin
                            r_p <= r_p + r_a;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end else begin
                        r_p <= '0;
                        case (r_phase)
                            PH_RC: begin
                                r_rc    <= r_p;
                                r_a     <= r_p;
                                r_b     <= 64'(sum_mag);
                                r_phase <= PH_V;
                            end
                            PH_V: begin
                                r_v     <= sat32(rnd(r_p, SH_V), r_sum[16]);
                                r_a     <= r_rc;
                                r_b     <= 64'(diff_mag);
                                r_phase <= PH_D;
                            end
                            PH_D: begin
                                r_a     <= rnd(r_p, SH_D);
                                r_b     <= 64'(r_itw);
                                r_phase <= PH_W;
                            end
                            PH_W: begin
                                r_w     <= sat32(rnd(r_p, 16), r_diff[16]);
                                r_cx    <= odo_pkg::CORDIC_GAIN_Q30;
                                r_cy    <= '0;
                                r_ca    <= ang0;
                                r_flip  <= flip0;
                                r_cnt   <= '0;
                                r_state <= ST_COR;
                            end
                            PH_VC: begin
                                r_a     <= rnd(r_p, 30);
                                r_b     <= 64'(r_dt);
                                r_phase <= PH_TX;
                            end
                            PH_TX: begin
                                r_dx    <= (r_v[31] ^ r_cs[33]) ? 48'(64'd0 - rnd(r_p, 16))
                                                                : 48'(rnd(r_p, 16));
                                r_a     <= 64'(v_mag);
                                r_b     <= 64'(sn_mag);
                                r_phase <= PH_VS;
                            end
                            PH_VS: begin
                                r_a     <= rnd(r_p, 30);
                                r_b     <= 64'(r_dt);
                                r_phase <= PH_TY;
                            end
                            PH_TY: begin
                                r_dy    <= (r_v[31] ^ r_sn[33]) ? 48'(64'd0 - rnd(r_p, 16))
                                                                : 48'(rnd(r_p, 16));
                                r_a     <= 64'(w_mag);
                                r_b     <= 64'(r_dt);
                                r_phase <= PH_P;
                            end
                            PH_P: begin
                                r_a     <= rnd(r_p, SH_F);
                                r_b     <= 64'(odo_pkg::INV2PI_Q24);
                                r_phase <= PH_ANG;
                            end
                            PH_ANG: begin
                                r_dang  <= r_w[31] ? 24'd0 - ang_bits : ang_bits;
                                r_state <= ST_UPD;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_COR: begin
                    r_cx  <= cx_nx;
                    r_cy  <= cy_nx;
                    r_ca  <= ca_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_cs    <= cs_fin;
                        r_sn    <= sn_fin;
                        r_a     <= 64'(v_mag);
                        r_b     <= 64'(cs_fin_mag);
                        r_p     <= '0;
                        r_phase <= PH_VC;
                        r_state <= ST_MUL;
                    end
                end
                ST_UPD: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_x                 <= x_new;
                        r_y                 <= y_new;
                        r_h                 <= h_new;
                        r_out.pos_x         <= x_new;
                        r_out.pos_y         <= y_new;
                        r_out.heading       <= h_new;
                        r_out.forward_speed <= r_v;
                        r_out.yaw_rate      <= r_w;
                        r_out_valid         <= 1'b1;
                        r_state             <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    `ODU_ASSERT(a_accept_starts_mul, (i_in_valid && !o_in_stall) |=> (r_state == ST_MUL), "accepted request did not start")
    `ODU_ASSERT(a_result_from_update, $rose(o_out_valid) |-> $past(r_state == ST_UPD), "result without update")
    `ODU_ASSERT(a_cordic_count, (r_state == ST_COR) |-> (r_cnt <= LAST_STEP), "rotation count out of range")
    `ODU_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
